>>> rtl/core/assert_macros.svh
// Assertion macros shared by the fault qualifier RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define MCFQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcfq assertion failed");
// Checked at every edge, reset included.
`define MCFQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mcfq assertion failed");
`else
`define MCFQ_ASSERT(label, prop)
`define MCFQ_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> rtl/core/mcfq_pkg.sv
// Shared types, constants and helper functions for the fault qualifier.
// No dependencies; used by mcfq_core and multi_channel_fault_qualifier.
package mcfq_pkg;

  // Default structure parameters
  localparam int TEMP_CHANNELS_DEF   = 4;
  localparam int CURRENT_CHANNELS_DEF = 6;
  localparam int QBH_PERIOD_DEF      = 24;
  localparam int FLOW_PERIOD_DEF     = 400;
  localparam int QBH_COUNT_LIMIT_DEF = 50;

  // Fixed field geometry
  localparam int MASK_W        = 14;
  localparam int TEMP_FIELDS   = 4;
  localparam int CURRENT_FIELDS = 6;
  localparam int CFG_DATA_W    = 14;
  localparam int CFG_IDX_W     = 3;

  // Photodiode gate thresholds
  localparam logic [6:0] PD_POWER_MIN   = 7'd5;
  localparam logic [9:0] PD_CURRENT_MIN = 10'd60;

  // Enable mask bit positions
  localparam int EN_PD1   = 0;
  localparam int EN_PD2   = 1;
  localparam int EN_QBH   = 2;
  localparam int EN_FLOW  = 3;
  localparam int EN_TEMP0 = 4;

  // Error codes
  localparam logic [3:0] CODE_NONE  = 4'd0;
  localparam logic [3:0] CODE_STOP  = 4'd1;
  localparam logic [3:0] CODE_PD2   = 4'd2;
  localparam logic [3:0] CODE_PD1   = 4'd3;
  localparam logic [3:0] CODE_QBH   = 4'd4;
  localparam logic [3:0] CODE_FLOW  = 4'd5;
  localparam logic [3:0] CODE_TEMP0 = 4'd6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_MASK    = 3'd0,
    REG_DRIVE_COUNT   = 3'd1,
    REG_TEMP_LIMIT    = 3'd2,
    REG_CURRENT_LIMIT = 3'd3,
    REG_PD_LIMIT      = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [MASK_W-1:0] ALARM_MASK_RST    = 14'h3FFF;
  localparam logic [2:0]        DRIVE_COUNT_RST   = 3'd6;
  localparam logic [7:0]        TEMP_LIMIT_RST    = 8'd60;
  localparam logic [9:0]        CURRENT_LIMIT_RST = 10'd1023;
  localparam logic [11:0]       PD_LIMIT_RST      = 12'd3250;

  typedef struct packed {
    logic [MASK_W-1:0] alarm_enable_mask;
    logic [2:0]        drive_count;
    logic [7:0]        temp_limit;
    logic [9:0]        current_limit;
    logic [11:0]       pd_voltage_limit;
  } cfg_t;

  typedef struct packed {
    logic        locked;
    logic        stop_active;
    logic        pd1_active;
    logic        qbh_low;
    logic        flow_high;
    logic        falling_edge_seen;
    logic [6:0]  power_percent;
    logic [11:0] pd2_millivolts;
    logic [31:0] temps_packed;
    logic [59:0] currents_packed;
  } in_item_t;

  typedef struct packed {
    logic       alarm;
    logic [3:0] error_code;
  } out_item_t;

  // Enable bit for a channel slot; slots past the mask are off
  function automatic logic chan_enabled(logic [MASK_W-1:0] mask, int idx);
    logic [31:0] m;
    m = 32'(mask);
    return (idx < MASK_W) && m[idx[4:0]];
  endfunction

  // Temperature k from the packed word; missing channels read zero
  function automatic logic [7:0] temp_of(logic [31:0] pk, int k);
    logic [31:0] s;
    s = pk >> (8 * k);
    return (k < TEMP_FIELDS) ? s[7:0] : 8'd0;
  endfunction

  // Current k from the packed word; missing channels read zero
  function automatic logic [9:0] current_of(logic [59:0] pk, int k);
    logic [59:0] s;
    s = pk >> (10 * k);
    return (k < CURRENT_FIELDS) ? s[9:0] : 10'd0;
  endfunction

endpackage

>>> rtl/core/mcfq_core.sv
// Channel qualifier state and single-pass next-state logic.
// Depends on mcfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcfq_core #(
  parameter int TEMP_CHANNELS    = mcfq_pkg::TEMP_CHANNELS_DEF,
  parameter int CURRENT_CHANNELS = mcfq_pkg::CURRENT_CHANNELS_DEF,
  parameter int QBH_PERIOD       = mcfq_pkg::QBH_PERIOD_DEF,
  parameter int FLOW_PERIOD      = mcfq_pkg::FLOW_PERIOD_DEF,
  parameter int QBH_COUNT_LIMIT  = mcfq_pkg::QBH_COUNT_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  mcfq_pkg::in_item_t  item,
  input  mcfq_pkg::cfg_t      cfg,
  output mcfq_pkg::out_item_t res
);
  import mcfq_pkg::*;

  localparam int QPW = $clog2(QBH_PERIOD + 2);
  localparam int FPW = $clog2(FLOW_PERIOD + 2);
  localparam int QCW = $clog2(QBH_COUNT_LIMIT + 2);

  logic [15:0]    pd2_hist_r, pd2_hist_nxt;
  logic [15:0]    pd1_hist_r, pd1_hist_nxt;
  logic [QPW-1:0] qbh_pre_r, qbh_pre_nxt;
  logic [QCW-1:0] qbh_cnt_r, qbh_cnt_nxt;
  logic [FPW-1:0] flow_pre_r, flow_pre_nxt;
  logic [15:0]    flow_hist_r, flow_hist_nxt;
  logic [7:0]     temp_hist_r [TEMP_CHANNELS];
  logic [7:0]     temp_hist_nxt [TEMP_CHANNELS];
  logic [7:0]     cur_hist_r [CURRENT_CHANNELS];
  logic [7:0]     cur_hist_nxt [CURRENT_CHANNELS];
  logic           alarm_r, alarm_nxt;
  logic [3:0]     code_r, code_nxt;

  always_comb begin
    logic           hit;
    logic [3:0]     code;
    logic           pd2v;
    logic [QCW-1:0] cnt_inc;

    pd2_hist_nxt  = pd2_hist_r;
    pd1_hist_nxt  = pd1_hist_r;
    qbh_pre_nxt   = qbh_pre_r;
    qbh_cnt_nxt   = qbh_cnt_r;
    flow_pre_nxt  = flow_pre_r;
    flow_hist_nxt = flow_hist_r;
    temp_hist_nxt = temp_hist_r;
    cur_hist_nxt  = cur_hist_r;
    hit     = 1'b0;
    code    = CODE_NONE;
    pd2v    = 1'b0;
    cnt_inc = qbh_cnt_r + 1'b1;

    // Locked or alarmed requests leave every history untouched
    if (step && !item.locked && !alarm_r) begin
      if (item.stop_active) begin
        hit  = 1'b1;
        code = CODE_STOP;
      end

      if (!item.falling_edge_seen && (item.power_percent > PD_POWER_MIN) &&
          (item.currents_packed[9:0] > PD_CURRENT_MIN)) begin
        pd2v = item.pd2_millivolts >= cfg.pd_voltage_limit;
        if (chan_enabled(cfg.alarm_enable_mask, EN_PD1) &&
            chan_enabled(cfg.alarm_enable_mask, EN_PD2)) begin
          // Both enabled: combined condition on the pd2 history, pd1 holds
          pd2_hist_nxt = {pd2_hist_r[14:0], pd2v & item.pd1_active};
          if (&pd2_hist_nxt) begin
            hit  = 1'b1;
            code = CODE_PD2;
          end
        end else begin
          if (chan_enabled(cfg.alarm_enable_mask, EN_PD2)) begin
            pd2_hist_nxt = {pd2_hist_r[14:0], pd2v};
            if (&pd2_hist_nxt) begin
              hit  = 1'b1;
              code = CODE_PD2;
            end
          end
          if (chan_enabled(cfg.alarm_enable_mask, EN_PD1)) begin
            pd1_hist_nxt = {pd1_hist_r[14:0], item.pd1_active};
            if (&pd1_hist_nxt) begin
              hit  = 1'b1;
              code = CODE_PD1;
            end
          end
        end
      end

      if (qbh_pre_r > QPW'(QBH_PERIOD)) begin
        qbh_pre_nxt = '0;
        if (chan_enabled(cfg.alarm_enable_mask, EN_QBH)) begin
          if (item.qbh_low) begin
            if (cnt_inc > QCW'(QBH_COUNT_LIMIT)) begin
              qbh_cnt_nxt = '0;
              hit         = 1'b1;
              code        = CODE_QBH;
            end else begin
              qbh_cnt_nxt = cnt_inc;
            end
          end else begin
            qbh_cnt_nxt = '0;
          end
        end
      end else begin
        qbh_pre_nxt = qbh_pre_r + 1'b1;
      end

      if (flow_pre_r > FPW'(FLOW_PERIOD)) begin
        flow_pre_nxt = '0;
        if (chan_enabled(cfg.alarm_enable_mask, EN_FLOW)) begin
          flow_hist_nxt = {flow_hist_r[14:0], item.flow_high};
          if (&flow_hist_nxt) begin
            hit  = 1'b1;
            code = CODE_FLOW;
          end
        end
      end else begin
        flow_pre_nxt = flow_pre_r + 1'b1;
      end

      // Later channels overwrite the code: last one in order wins
      for (int k = 0; k < TEMP_CHANNELS; k++) begin
        if (chan_enabled(cfg.alarm_enable_mask, EN_TEMP0 + k)) begin
          temp_hist_nxt[k] = {temp_hist_r[k][6:0],
                              temp_of(item.temps_packed, k) >= cfg.temp_limit};
          if (&temp_hist_nxt[k]) begin
            hit  = 1'b1;
            code = CODE_TEMP0 + 4'(k);
          end
        end
      end

      for (int k = 0; k < CURRENT_CHANNELS; k++) begin
        if (chan_enabled(cfg.alarm_enable_mask, EN_TEMP0 + TEMP_CHANNELS + k) &&
            ({1'b0, cfg.drive_count} >= 4'(k + 1))) begin
          cur_hist_nxt[k] = {cur_hist_r[k][6:0],
                             current_of(item.currents_packed, k) >= cfg.current_limit};
          if (&cur_hist_nxt[k]) begin
            hit  = 1'b1;
            code = CODE_TEMP0 + 4'(TEMP_CHANNELS) + 4'(k);
          end
        end
      end
    end

    alarm_nxt = alarm_r | hit;
    code_nxt  = hit ? code : code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd2_hist_r  <= '0;
      pd1_hist_r  <= '0;
      qbh_pre_r   <= '0;
      qbh_cnt_r   <= '0;
      flow_pre_r  <= '0;
      flow_hist_r <= '0;
      for (int k = 0; k < TEMP_CHANNELS; k++) begin
        temp_hist_r[k] <= '0;
      end
      for (int k = 0; k < CURRENT_CHANNELS; k++) begin
        cur_hist_r[k] <= '0;
      end
      alarm_r <= 1'b0;
      code_r  <= CODE_NONE;
    end else begin
      pd2_hist_r  <= pd2_hist_nxt;
      pd1_hist_r  <= pd1_hist_nxt;
      qbh_pre_r   <= qbh_pre_nxt;
      qbh_cnt_r   <= qbh_cnt_nxt;
      flow_pre_r  <= flow_pre_nxt;
      flow_hist_r <= flow_hist_nxt;
      temp_hist_r <= temp_hist_nxt;
      cur_hist_r  <= cur_hist_nxt;
      alarm_r     <= alarm_nxt;
      code_r      <= code_nxt;
    end
  end

  assign res.alarm      = alarm_nxt;
  assign res.error_code = code_nxt;

  `MCFQ_ASSERT(a_alarm_sticky, alarm_r |=> alarm_r)
  `MCFQ_ASSERT(a_code_frozen, alarm_r |=> $stable(code_r))
  `MCFQ_ASSERT(a_code_needs_alarm, !alarm_r |-> code_r == CODE_NONE)
  `MCFQ_ASSERT(a_locked_holds, step && item.locked |=> $stable(qbh_pre_r) && $stable(flow_pre_r))

endmodule

>>> rtl/core/multi_channel_fault_qualifier.sv
// Top level of the multi-channel fault qualifier: handshakes, config, staging.
// Depends on mcfq_pkg, mcfq_core and assert_macros.svh.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | in_item  (mcfq_pkg::in_item_t)
//   out_       | out | out_valid/out_ready| out_item (mcfq_pkg::out_item_t)
//   cfg_       | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready is high; out_valid rises once a
// request passes the input register, then qualifier update into the result register.
// Reset is synchronous, active low: clears histories and alarm, loads config defaults.
// in_ready drops only while both the input register and the result register
// are full and out_ready is low.
`include "assert_macros.svh"

module multi_channel_fault_qualifier #(
  parameter int TEMP_CHANNELS    = mcfq_pkg::TEMP_CHANNELS_DEF,
  parameter int CURRENT_CHANNELS = mcfq_pkg::CURRENT_CHANNELS_DEF,
  parameter int QBH_PERIOD       = mcfq_pkg::QBH_PERIOD_DEF,
  parameter int FLOW_PERIOD      = mcfq_pkg::FLOW_PERIOD_DEF,
  parameter int QBH_COUNT_LIMIT  = mcfq_pkg::QBH_COUNT_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mcfq_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mcfq_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [mcfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcfq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mcfq_pkg::*;

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t core_res;
  logic      adv;

  // Advance the staged request when the result slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_enable_mask <= ALARM_MASK_RST;
      cfg_r.drive_count       <= DRIVE_COUNT_RST;
      cfg_r.temp_limit        <= TEMP_LIMIT_RST;
      cfg_r.current_limit     <= CURRENT_LIMIT_RST;
      cfg_r.pd_voltage_limit  <= PD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALARM_MASK:    cfg_r.alarm_enable_mask <= cfg_wdata[MASK_W-1:0];
        REG_DRIVE_COUNT:   cfg_r.drive_count       <= cfg_wdata[2:0];
        REG_TEMP_LIMIT:    cfg_r.temp_limit        <= cfg_wdata[7:0];
        REG_CURRENT_LIMIT: cfg_r.current_limit     <= cfg_wdata[9:0];
        REG_PD_LIMIT:      cfg_r.pd_voltage_limit  <= cfg_wdata[11:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= core_res;
    end
  end

  mcfq_core #(
    .TEMP_CHANNELS    (TEMP_CHANNELS),
    .CURRENT_CHANNELS (CURRENT_CHANNELS),
    .QBH_PERIOD       (QBH_PERIOD),
    .FLOW_PERIOD      (FLOW_PERIOD),
    .QBH_COUNT_LIMIT  (QBH_COUNT_LIMIT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `MCFQ_ASSERT(a_stall_only_when_full, !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
  `MCFQ_ASSERT(a_adv_fills_out, adv |=> out_valid_r)
  `MCFQ_ASSERT(a_code_without_alarm, out_valid_r && !out_item_r.alarm |-> out_item_r.error_code == CODE_NONE)
  `MCFQ_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule
